// File: rtl/core/fcb_pkg.sv
// Shared types and codes for the fragment color blender.
// No dependencies; imported by fcb_factor, fcb_channel and fragment_color_blender.
`timescale 1ns / 1ps
`default_nettype none

package fcb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned WeightW = 9;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegEquation  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSrcFactor = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDstFactor = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSrcFixed  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDstFixed  = 3'd4;

  typedef enum logic [2:0] {
    EQ_ADD     = 3'd0,
    EQ_SUB     = 3'd1,
    EQ_REV_SUB = 3'd2,
    EQ_MIN     = 3'd3,
    EQ_MAX     = 3'd4,
    EQ_ABS_DIF = 3'd5
  } fcb_eq_t;

  typedef enum logic [3:0] {
    FS_OTHER        = 4'd0,
    FS_INV_OTHER    = 4'd1,
    FS_SRC_A        = 4'd2,
    FS_INV_SRC_A    = 4'd3,
    FS_DST_A        = 4'd4,
    FS_INV_DST_A    = 4'd5,
    FS_SRC_A2       = 4'd6,
    FS_INV_SRC_A2   = 4'd7,
    FS_DST_A2       = 4'd8,
    FS_INV_DST_A2   = 4'd9,
    FS_FIXED        = 4'd10
  } fcb_factor_t;

  // Blend mode shared by all three channel slices
  typedef struct packed {
    fcb_eq_t     eq;
    fcb_factor_t src_sel;
    fcb_factor_t dst_sel;
  } fcb_mode_t;

endpackage

`default_nettype wire

// File: rtl/core/fcb_factor.sv
// Blend weight selection for one side of one color channel.
// Depends on fcb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcb_factor (
  input  fcb_pkg::fcb_factor_t          sel,
  input  logic [fcb_pkg::ChanW-1:0]     other,
  input  logic [fcb_pkg::ChanW-1:0]     src_a,
  input  logic [fcb_pkg::ChanW-1:0]     dst_a,
  input  logic [fcb_pkg::ChanW-1:0]     fixed_c,
  output logic [fcb_pkg::WeightW-1:0]   weight
);
  import fcb_pkg::*;

  logic [WeightW-1:0] src_a2;
  logic [WeightW-1:0] dst_a2;
  logic [ChanW-1:0]   src_a2_sat;
  logic [ChanW-1:0]   dst_a2_sat;

  assign src_a2     = {src_a, 1'b0};
  assign dst_a2     = {dst_a, 1'b0};
  // doubled alpha saturates at full scale only for the one-minus forms
  assign src_a2_sat = src_a2[WeightW-1] ? ChanMax : src_a2[ChanW-1:0];
  assign dst_a2_sat = dst_a2[WeightW-1] ? ChanMax : dst_a2[ChanW-1:0];

  always_comb begin
    case (sel)
      FS_OTHER:      weight = {1'b0, other};
      FS_INV_OTHER:  weight = {1'b0, ChanMax - other};
      FS_SRC_A:      weight = {1'b0, src_a};
      FS_INV_SRC_A:  weight = {1'b0, ChanMax - src_a};
      FS_DST_A:      weight = {1'b0, dst_a};
      FS_INV_DST_A:  weight = {1'b0, ChanMax - dst_a};
      FS_SRC_A2:     weight = src_a2;
      FS_INV_SRC_A2: weight = {1'b0, ChanMax - src_a2_sat};
      FS_DST_A2:     weight = dst_a2;
      FS_INV_DST_A2: weight = {1'b0, ChanMax - dst_a2_sat};
      default:       weight = {1'b0, fixed_c};
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/fcb_channel.sv
// One color channel of the blender: weights, products, combine and clamp.
// Depends on fcb_pkg and fcb_factor.
`timescale 1ns / 1ps
`default_nettype none

module fcb_channel (
  input  fcb_pkg::fcb_mode_t           mode,
  input  logic [fcb_pkg::ChanW-1:0]    src_c,
  input  logic [fcb_pkg::ChanW-1:0]    dst_c,
  input  logic [fcb_pkg::ChanW-1:0]    src_a,
  input  logic [fcb_pkg::ChanW-1:0]    dst_a,
  input  logic [fcb_pkg::ChanW-1:0]    src_fixed,
  input  logic [fcb_pkg::ChanW-1:0]    dst_fixed,
  output logic [fcb_pkg::ChanW-1:0]    result
);
  import fcb_pkg::*;

  localparam int unsigned ProdW = (ChanW + 1) + (WeightW + 1);
  localparam int unsigned SumW  = WeightW + 2;

  logic [WeightW-1:0]     src_w;
  logic [WeightW-1:0]     dst_w;
  logic [ProdW-1:0]       src_prod;
  logic [ProdW-1:0]       dst_prod;
  logic [WeightW-1:0]     src_term;
  logic [WeightW-1:0]     dst_term;
  logic signed [SumW-1:0] src_s;
  logic signed [SumW-1:0] dst_s;
  logic signed [SumW-1:0] mix;

  fcb_factor u_src_factor (
    .sel     (mode.src_sel),
    .other   (dst_c),
    .src_a   (src_a),
    .dst_a   (dst_a),
    .fixed_c (src_fixed),
    .weight  (src_w)
  );

  fcb_factor u_dst_factor (
    .sel     (mode.dst_sel),
    .other   (src_c),
    .src_a   (src_a),
    .dst_a   (dst_a),
    .fixed_c (dst_fixed),
    .weight  (dst_w)
  );

  // (2c+1)*(2f+1), then drop ten bits
  assign src_prod = ProdW'({src_c, 1'b1}) * ProdW'({src_w, 1'b1});
  assign dst_prod = ProdW'({dst_c, 1'b1}) * ProdW'({dst_w, 1'b1});
  assign src_term = src_prod[ProdW-1 -: WeightW];
  assign dst_term = dst_prod[ProdW-1 -: WeightW];
  assign src_s    = signed'({2'b00, src_term});
  assign dst_s    = signed'({2'b00, dst_term});

  always_comb begin
    case (mode.eq)
      EQ_ADD:     mix = src_s + dst_s;
      EQ_SUB:     mix = src_s - dst_s;
      EQ_REV_SUB: mix = dst_s - src_s;
      EQ_MIN:     mix = signed'({3'b000, (src_c < dst_c) ? src_c : dst_c});
      EQ_MAX:     mix = signed'({3'b000, (src_c > dst_c) ? src_c : dst_c});
      EQ_ABS_DIF: mix = signed'({3'b000,
                                 (src_c > dst_c) ? src_c - dst_c : dst_c - src_c});
      default:    mix = '0;
    endcase
  end

  always_comb begin
    if (mix < 0) begin
      result = '0;
    end else if (mix > signed'({3'b000, ChanMax})) begin
      result = ChanMax;
    end else begin
      result = mix[ChanW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fragment_color_blender.sv
// Top level of the fragment color blender: ports, config registers, pipeline.
// Depends on fcb_pkg and fcb_channel.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  s_*     | in        | s_tvalid / s_tready    | s_tdata: src RGBA, dst RGBA (8b each)
//  m_*     | out       | m_tvalid / m_tready    | m_tdata: out red, green, blue
//  cfg_*   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per clock sustained while m_tready stays high. An accepted item sits in
// the input register and moves to the result register, where m_tvalid marks it,
// once that register is empty or its item is being taken. The whole blend sits
// in the logic between the two registers: weight mux, one 9x10 multiply per side
// and channel, combine and clamp. Synchronous reset clears both valid bits and
// loads the register defaults. A stalled output holds its item; the input register
// drains into the result register whenever that one is empty or being taken, so
// input stalls only when both stages are full and the result item is not being
// taken.
`timescale 1ns / 1ps
`default_nettype none

module fragment_color_blender (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] src_red, [15:8] src_green, [23:16] src_blue, [31:24] src_alpha,
  // [39:32] dst_red, [47:40] dst_green, [55:48] dst_blue, [63:56] dst_alpha
  input  logic [63:0]                    s_tdata,
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic [23:0]                    m_tdata,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fcb_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [fcb_pkg::CfgDatW-1:0]    cfg_data
);
  import fcb_pkg::*;

  localparam int unsigned NumCh = 3;

  // configuration registers
  fcb_mode_t          mode;
  logic [CfgDatW-1:0] src_fixed;
  logic [CfgDatW-1:0] dst_fixed;

  // pipeline
  logic               in_valid;
  logic [63:0]        in_data;
  logic               in_advance;
  logic [23:0]        blend;

  // writes are always taken; the user must write only while the block is idle, as the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode.eq      <= EQ_ADD;
      mode.src_sel <= FS_SRC_A;
      mode.dst_sel <= FS_INV_SRC_A;
      src_fixed    <= '0;
      dst_fixed    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegEquation:  mode.eq      <= fcb_eq_t'(cfg_data[2:0]);
        RegSrcFactor: mode.src_sel <= fcb_factor_t'(cfg_data[3:0]);
        RegDstFactor: mode.dst_sel <= fcb_factor_t'(cfg_data[3:0]);
        RegSrcFixed:  src_fixed    <= cfg_data;
        RegDstFixed:  dst_fixed    <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // advance the input stage when the result stage is free or draining
  assign in_advance = !m_tvalid || m_tready;
  assign s_tready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  // one slice per color channel; alpha bytes are shared
  for (genvar ch = 0; ch < NumCh; ch++) begin : g_ch
    fcb_channel u_channel (
      .mode      (mode),
      .src_c     (in_data[ChanW*ch +: ChanW]),
      .dst_c     (in_data[ChanW*(ch+4) +: ChanW]),
      .src_a     (in_data[ChanW*3 +: ChanW]),
      .dst_a     (in_data[ChanW*7 +: ChanW]),
      .src_fixed (src_fixed[ChanW*ch +: ChanW]),
      .dst_fixed (dst_fixed[ChanW*ch +: ChanW]),
      .result    (blend[ChanW*ch +: ChanW])
    );
  end

  // result register: hold while stalled, load from the input stage otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_valid) begin
      m_tdata <= blend;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fcb_checker.sv
// Port-level checks for the fragment color blender, bound to its top level.
// Depends on fragment_color_blender (bind target) only.
`timescale 1ns / 1ps
`default_nettype none

module fcb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // an accepted item reaches the output in the cycle after the output is ready
  a_item_flows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
    else $error("accepted item did not reach the output");

endmodule

bind fragment_color_blender fcb_checker u_fcb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
